### sv/bvp_pkg.sv
// Shared types, constants and curve table for the battery voltage to percent block.
package bvp_pkg;

    localparam int unsigned NumPoints = 21;
    localparam int unsigned MvW       = 13;
    localparam int unsigned PctW      = 7;
    localparam int unsigned SegW      = 5;
    localparam int unsigned DiffW     = 9;   // widest span between curve points is 340 mV

    localparam logic [PctW-1:0] StepPct = 7'd5;
    localparam logic [PctW-1:0] MaxPct  = 7'd100;
    localparam logic [PctW-1:0] MinPct  = 7'd0;

    // configuration register indexes
    localparam logic [1:0] CfgLowPct      = 2'd0;
    localparam logic [1:0] CfgCriticalPct = 2'd1;
    localparam logic [1:0] CfgEmptyPct    = 2'd2;
    localparam logic [1:0] CfgChargingMv  = 2'd3;

    localparam logic [PctW-1:0] RstLowPct      = 7'd25;
    localparam logic [PctW-1:0] RstCriticalPct = 7'd10;
    localparam logic [PctW-1:0] RstEmptyPct    = 7'd5;
    localparam logic [MvW-1:0]  RstChargingMv  = 13'd4300;

    // segment-select result handed to the interpolation stage
    typedef struct packed {
        logic [PctW-1:0]  base;
        logic [DiffW-1:0] diff;
        logic [DiffW-1:0] span;
        logic             sat_hi;
        logic             sat_lo;
        logic             charging;
    } t_seg;

    typedef struct packed {
        logic [PctW-1:0] percent;
        logic            charging;
    } t_pct;

    function automatic logic [MvW-1:0] curve_mv(input logic [SegW-1:0] idx);
        logic [MvW-1:0] mv;
        unique case (idx)
            5'd0:    mv = 13'd3270;
            5'd1:    mv = 13'd3610;
            5'd2:    mv = 13'd3690;
            5'd3:    mv = 13'd3710;
            5'd4:    mv = 13'd3730;
            5'd5:    mv = 13'd3750;
            5'd6:    mv = 13'd3770;
            5'd7:    mv = 13'd3790;
            5'd8:    mv = 13'd3800;
            5'd9:    mv = 13'd3820;
            5'd10:   mv = 13'd3840;
            5'd11:   mv = 13'd3850;
            5'd12:   mv = 13'd3870;
            5'd13:   mv = 13'd3910;
            5'd14:   mv = 13'd3950;
            5'd15:   mv = 13'd3980;
            5'd16:   mv = 13'd4020;
            5'd17:   mv = 13'd4080;
            5'd18:   mv = 13'd4110;
            5'd19:   mv = 13'd4150;
            5'd20:   mv = 13'd4200;
            default: mv = 13'd4200;
        endcase
        return mv;
    endfunction

endpackage

### sv/bvp_seg_sel.sv
// Two pipeline stages: curve point compares, then segment select and offset.
module bvp_seg_sel (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [bvp_pkg::MvW-1:0]   i_voltage_mv,
    input  logic [bvp_pkg::MvW-1:0]   i_charging_mv,
    output logic                      o_valid,
    input  logic                      i_ready,
    output bvp_pkg::t_seg             o_seg
);

    logic                                 r_vld1;
    logic [bvp_pkg::MvW-1:0]              r_v1;
    logic [bvp_pkg::NumPoints-1:0]        r_thermo1;
    logic                                 r_sat_lo1;
    logic                                 r_chg1;
    logic                                 r_vld2;
    bvp_pkg::t_seg                        r_seg2;

    logic                                 en1;
    logic                                 en2;
    logic [bvp_pkg::NumPoints-1:0]        n_thermo;
    logic [bvp_pkg::SegW-1:0]             seg;
    logic [bvp_pkg::SegW-1:0]             seg_m1;
    logic [bvp_pkg::MvW-1:0]              lo_mv;
    logic [bvp_pkg::MvW-1:0]              hi_mv;
    logic [bvp_pkg::MvW-1:0]              span_full;
    logic [bvp_pkg::MvW-1:0]              diff_full;
    bvp_pkg::t_seg                        n_seg;

    assign en2     = !r_vld2 || i_ready;
    assign en1     = !r_vld1 || en2;
    assign o_ready = en1;
    assign o_valid = r_vld2;
    assign o_seg   = r_seg2;

    always_comb begin
        for (int k = 0; k < bvp_pkg::NumPoints; k++) begin
            n_thermo[k] = i_voltage_mv >= bvp_pkg::curve_mv(bvp_pkg::SegW'(k));
        end
    end

    // thermometer code: number of interior points at or below v picks the segment
    always_comb begin
        seg       = bvp_pkg::SegW'($countones(r_thermo1[bvp_pkg::NumPoints-2:1])) + 5'd1;
        seg_m1    = seg - 5'd1;
        lo_mv     = bvp_pkg::curve_mv(seg_m1);
        hi_mv     = bvp_pkg::curve_mv(seg);
        span_full = hi_mv - lo_mv;
        diff_full = r_v1 - lo_mv;
        n_seg.base     = bvp_pkg::PctW'(seg_m1) * bvp_pkg::StepPct;
        n_seg.diff     = diff_full[bvp_pkg::DiffW-1:0];
        n_seg.span     = span_full[bvp_pkg::DiffW-1:0];
        n_seg.sat_hi   = r_thermo1[bvp_pkg::NumPoints-1];
        n_seg.sat_lo   = r_sat_lo1;
        n_seg.charging = r_chg1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_valid;
            if (en2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_v1      <= i_voltage_mv;
            r_thermo1 <= n_thermo;
            r_sat_lo1 <= i_voltage_mv <= bvp_pkg::curve_mv(5'd0);
            r_chg1    <= i_voltage_mv > i_charging_mv;
        end
        if (en2) begin
            r_seg2 <= n_seg;
        end
    end

endmodule

### sv/bvp_interp.sv
// Interpolation stage: offset times step over segment span, added to segment base; saturates to 100 or 0 %.
module bvp_interp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bvp_pkg::t_seg i_seg,
    output logic          o_valid,
    input  logic          i_ready,
    output bvp_pkg::t_pct o_pct
);

    localparam int unsigned ProdW = bvp_pkg::DiffW + 2;

    logic                          r_vld;
    bvp_pkg::t_pct                 r_pct;
    logic                          en;
    logic [ProdW-1:0]              diff5;
    logic [ProdW-1:0]              span_w;
    logic [2:0]                    quot;
    bvp_pkg::t_pct                 n_pct;

    assign en      = !r_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld;
    assign o_pct   = r_pct;

    // quotient is 0..4, so the divide is four compares against multiples of the span
    always_comb begin
        diff5  = ProdW'(i_seg.diff) * ProdW'(bvp_pkg::StepPct);
        span_w = ProdW'(i_seg.span);
        quot   = 3'd0;
        for (int k = 1; k < 5; k++) begin
            if (diff5 >= ProdW'(k) * span_w) quot = quot + 3'd1;
        end
        if (i_seg.sat_hi) begin
            n_pct.percent = bvp_pkg::MaxPct;
        end else if (i_seg.sat_lo) begin
            n_pct.percent = bvp_pkg::MinPct;
        end else begin
            n_pct.percent = i_seg.base + bvp_pkg::PctW'(quot);
        end
        n_pct.charging = i_seg.charging;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_pct <= n_pct;
    end

endmodule

### sv/battery_voltage_to_percent_top.sv
// Top level: config registers, segment select, interpolation and flag output stage.
// Stages, each registered: compare, select, interpolate, flags. Throughput: one voltage per cycle
// unless the output stalls; every stage advances when the next one is empty or moving.
// The output register holds a result while the next items enter behind it until the stages fill.
// Reset (synchronous, active low) empties the pipeline and loads thresholds 25/10/5 % and 4300 mV.
module battery_voltage_to_percent_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [12:0] voltage_mv, [15:13] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] percent, [7] low_flag, [8] critical_flag,
                                        // [9] empty_flag, [10] charging_flag, [15:11] zero
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_wr_data
);

    logic [bvp_pkg::PctW-1:0] r_low_pct;
    logic [bvp_pkg::PctW-1:0] r_crit_pct;
    logic [bvp_pkg::PctW-1:0] r_empty_pct;
    logic [bvp_pkg::MvW-1:0]  r_chg_mv;

    logic                     seg_vld;
    logic                     seg_rdy;
    bvp_pkg::t_seg            seg;
    logic                     pct_vld;
    logic                     out_en;
    bvp_pkg::t_pct            pct;

    logic                     r_out_vld;
    logic [bvp_pkg::PctW-1:0] r_percent;
    logic                     r_low;
    logic                     r_crit;
    logic                     r_empty;
    logic                     r_chg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_pct   <= bvp_pkg::RstLowPct;
            r_crit_pct  <= bvp_pkg::RstCriticalPct;
            r_empty_pct <= bvp_pkg::RstEmptyPct;
            r_chg_mv    <= bvp_pkg::RstChargingMv;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                bvp_pkg::CfgLowPct:      r_low_pct   <= i_cfg_wr_data[bvp_pkg::PctW-1:0];
                bvp_pkg::CfgCriticalPct: r_crit_pct  <= i_cfg_wr_data[bvp_pkg::PctW-1:0];
                bvp_pkg::CfgEmptyPct:    r_empty_pct <= i_cfg_wr_data[bvp_pkg::PctW-1:0];
                bvp_pkg::CfgChargingMv:  r_chg_mv    <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    bvp_seg_sel u_seg_sel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_voltage_mv  (s_axis_tdata[bvp_pkg::MvW-1:0]),
        .i_charging_mv (r_chg_mv),
        .o_valid       (seg_vld),
        .i_ready       (seg_rdy),
        .o_seg         (seg)
    );

    bvp_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seg_vld),
        .o_ready (seg_rdy),
        .i_seg   (seg),
        .o_valid (pct_vld),
        .i_ready (out_en),
        .o_pct   (pct)
    );

    assign out_en = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_en) begin
            r_out_vld <= pct_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_percent <= pct.percent;
            r_low     <= pct.percent <= r_low_pct;
            r_crit    <= pct.percent <= r_crit_pct;
            r_empty   <= pct.percent <= r_empty_pct;
            r_chg     <= pct.charging;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_chg, r_empty, r_crit, r_low, r_percent};

endmodule
